### sv/hrr_pkg.sv
package hrr_pkg;

    localparam int NUM_REGS    = 8;
    localparam int IDX_W       = 3;
    localparam int FRONT_STG   = 4;
    localparam int STEPS_PER   = 2;
    localparam int QUO_W       = 40;
    localparam int DIV_STG     = QUO_W / STEPS_PER;
    localparam int NUM_STG     = FRONT_STG + DIV_STG + 1;
    localparam int NLO_W       = 24;

    localparam logic [31:0] ONE_Q20 = 32'h0010_0000;
    localparam logic signed [43:0] RES_MAX = 44'sh000_7FFF_FFFF;
    localparam logic signed [43:0] RES_MIN = -44'sh000_8000_0000;
    localparam logic [40:0] QUO_CLAMP = 41'h100_0000_0000;

    localparam logic [IDX_W-1:0] IDX_R0C0 = 3'd0;
    localparam logic [IDX_W-1:0] IDX_R1C1 = 3'd4;

    typedef logic [NUM_REGS-1:0][31:0] hom_t;

    // identity: entries (0,0) and (1,1) at 1.0
    localparam hom_t HOM_RESET = {32'h0, 32'h0, 32'h0, ONE_Q20,
                                  32'h0, 32'h0, 32'h0, ONE_Q20};

    typedef struct packed {
        logic [63:0]      rem;
        logic [NLO_W-1:0] nlo;
        logic [QUO_W-1:0] quo;
        logic             ovf;
        logic             neg;
        logic             num_neg;
    } lane_t;

    typedef struct packed {
        lane_t        lx;
        lane_t        ly;
        logic [63:0]  den;
        logic         zero;
        logic [31:0]  ref_x;
        logic [31:0]  ref_y;
        logic         last;
    } item_t;

    function automatic lane_t div_steps(lane_t l, logic [63:0] d);
        lane_t       r;
        logic [63:0] t;
        r = l;
        for (int i = 0; i < STEPS_PER; i++)
        begin
            t     = {r.rem[62:0], r.nlo[NLO_W-1]};
            r.nlo = {r.nlo[NLO_W-2:0], 1'b0};
            if (t >= d)
            begin
                r.rem = t - d;
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = t;
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

### sv/hrr_front.sv
module hrr_front (
    input  logic                           clk,
    input  logic [hrr_pkg::FRONT_STG-1:0]  en,
    input  hrr_pkg::hom_t                  hom,
    input  logic signed [31:0]             src_x,
    input  logic signed [31:0]             src_y,
    input  logic signed [31:0]             src_w,
    input  logic [31:0]                    ref_x,
    input  logic [31:0]                    ref_y,
    input  logic                           last_point,
    output hrr_pkg::item_t                 item
);
    import hrr_pkg::*;

    // products
    logic signed [63:0] p_reg [8];
    logic signed [31:0] w0_reg;
    logic [31:0]        rx0_reg, ry0_reg, rx1_reg, ry1_reg, rx2_reg, ry2_reg;
    logic               l0_reg, l1_reg, l2_reg;
    // row sums
    logic signed [63:0] q0_reg, q1_reg, q2_reg;
    logic signed [63:0] q0_next, q1_next, q2_next;
    // magnitudes
    logic [63:0]        n0_reg, n1_reg, d_reg;
    logic               s0_reg, s1_reg, s2_reg, z_reg;
    item_t              item_reg, item_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg[0] <= $signed(hom[0]) * src_x;
            p_reg[1] <= $signed(hom[1]) * src_y;
            p_reg[2] <= $signed(hom[2]) * src_w;
            p_reg[3] <= $signed(hom[3]) * src_x;
            p_reg[4] <= $signed(hom[4]) * src_y;
            p_reg[5] <= $signed(hom[5]) * src_w;
            p_reg[6] <= $signed(hom[6]) * src_x;
            p_reg[7] <= $signed(hom[7]) * src_y;
            w0_reg   <= src_w;
            rx0_reg  <= ref_x;
            ry0_reg  <= ref_y;
            l0_reg   <= last_point;
        end
    end

    always_comb
    begin
        q0_next = (p_reg[0] >>> 2) + (p_reg[1] >>> 2) + (p_reg[2] >>> 2);
        q1_next = (p_reg[3] >>> 2) + (p_reg[4] >>> 2) + (p_reg[5] >>> 2);
        q2_next = (p_reg[6] >>> 2) + (p_reg[7] >>> 2)
                + $signed({{14{w0_reg[31]}}, w0_reg, 18'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            q0_reg  <= q0_next;
            q1_reg  <= q1_next;
            q2_reg  <= q2_next;
            rx1_reg <= rx0_reg;
            ry1_reg <= ry0_reg;
            l1_reg  <= l0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            n0_reg  <= q0_reg[63] ? 64'(-q0_reg) : 64'(q0_reg);
            n1_reg  <= q1_reg[63] ? 64'(-q1_reg) : 64'(q1_reg);
            d_reg   <= q2_reg[63] ? 64'(-q2_reg) : 64'(q2_reg);
            s0_reg  <= q0_reg[63];
            s1_reg  <= q1_reg[63];
            s2_reg  <= q2_reg[63];
            z_reg   <= (q2_reg == 64'sd0);
            rx2_reg <= rx1_reg;
            ry2_reg <= ry1_reg;
            l2_reg  <= l1_reg;
        end
    end

    always_comb
    begin
        item_next.lx.rem     = n0_reg >> NLO_W;
        item_next.lx.nlo     = n0_reg[NLO_W-1:0];
        item_next.lx.quo     = '0;
        item_next.lx.ovf     = {24'b0, n0_reg} >= {d_reg, 24'b0};
        item_next.lx.neg     = s0_reg ^ s2_reg;
        item_next.lx.num_neg = s0_reg;
        item_next.ly.rem     = n1_reg >> NLO_W;
        item_next.ly.nlo     = n1_reg[NLO_W-1:0];
        item_next.ly.quo     = '0;
        item_next.ly.ovf     = {24'b0, n1_reg} >= {d_reg, 24'b0};
        item_next.ly.neg     = s1_reg ^ s2_reg;
        item_next.ly.num_neg = s1_reg;
        item_next.den        = d_reg;
        item_next.zero       = z_reg;
        item_next.ref_x      = rx2_reg;
        item_next.ref_y      = ry2_reg;
        item_next.last       = l2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

### sv/hrr_div_stage.sv
module hrr_div_stage (
    input  logic            clk,
    input  logic            en,
    input  hrr_pkg::item_t  item_in,
    output hrr_pkg::item_t  item_out
);
    import hrr_pkg::*;

    item_t item_reg, item_next;

    always_comb
    begin
        item_next    = item_in;
        item_next.lx = div_steps(item_in.lx, item_in.den);
        item_next.ly = div_steps(item_in.ly, item_in.den);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

### sv/hrr_back.sv
module hrr_back (
    input  logic               clk,
    input  logic               en,
    input  hrr_pkg::item_t     item,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic               zero_denominator,
    output logic               last_result
);
    import hrr_pkg::*;

    logic [31:0] rx_reg, ry_reg, rx_next, ry_next;
    logic        z_reg, l_reg;

    function automatic logic [31:0] lane_result(lane_t l, logic zero, logic [31:0] r);
        logic [40:0]        q;
        logic signed [43:0] p;
        logic signed [43:0] diff;
        logic [31:0]        res;
        q = l.ovf ? QUO_CLAMP : {1'b0, l.quo};
        p = l.neg ? -$signed({3'b0, q}) : $signed({3'b0, q});
        diff = p - $signed({{12{r[31]}}, r});
        if (zero)
        begin
            res = l.num_neg ? RES_MIN[31:0] : RES_MAX[31:0];
        end
        else if (diff > RES_MAX)
        begin
            res = RES_MAX[31:0];
        end
        else if (diff < RES_MIN)
        begin
            res = RES_MIN[31:0];
        end
        else
        begin
            res = diff[31:0];
        end
        return res;
    endfunction

    always_comb
    begin
        rx_next = lane_result(item.lx, item.zero, item.ref_x);
        ry_next = lane_result(item.ly, item.zero, item.ref_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            z_reg  <= item.zero;
            l_reg  <= item.last;
        end
    end

    assign res_x            = rx_reg;
    assign res_y            = ry_reg;
    assign zero_denominator = z_reg;
    assign last_result      = l_reg;

endmodule

### sv/homography_reprojection_residual_unit.sv
// Homography reprojection residual unit.
// Input channel (in_valid/in_ready): one point correspondence per transfer,
// src_x/src_y/src_w and ref_x/ref_y in Q16.16 plus last_point.
// Output channel (out_valid/out_ready): res_x/res_y in Q16.16, saturated,
// zero_denominator and last_result, one result per input transfer, in order.
// Config port: cfg_we writes cfg_data into homography entry cfg_index
// (0..7, row-major, Q12.20); entry (2,2) is fixed at 1.0. Write only when
// the pipeline is empty.
// Pipeline: 25 register stages: 4 front stages (multiply, row sum,
// magnitude, overflow check), 20 divider stages at two quotient bits
// each, one output stage.
// Throughput: one transfer per cycle; every stage is loaded independently.
// When the receiver stalls, items collapse into empty stages; in_ready
// drops only once all 25 stages hold data.
// Reset clears all stage valid bits and loads the identity homography.
module homography_reprojection_residual_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hrr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [31:0]         src_x,
    input  logic signed [31:0]         src_y,
    input  logic signed [31:0]         src_w,
    input  logic signed [31:0]         ref_x,
    input  logic signed [31:0]         ref_y,
    input  logic                       last_point,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [31:0]         res_x,
    output logic signed [31:0]         res_y,
    output logic                       zero_denominator,
    output logic                       last_result
);
    import hrr_pkg::*;

    hom_t                hom_reg;
    logic [NUM_STG-1:0]  v_reg;
    logic [NUM_STG-1:0]  en;
    item_t               div_item [DIV_STG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hom_reg <= HOM_RESET;
        end
        else if (cfg_we)
        begin
            hom_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        en[NUM_STG-1] = !v_reg[NUM_STG-1] || out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    hrr_front u_front (
        .clk        (clk),
        .en         (en[FRONT_STG-1:0]),
        .hom        (hom_reg),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_w      (src_w),
        .ref_x      (ref_x),
        .ref_y      (ref_y),
        .last_point (last_point),
        .item       (div_item[0])
    );

    for (genvar g = 0; g < DIV_STG; g++)
    begin : g_div
        hrr_div_stage u_stage (
            .clk      (clk),
            .en       (en[FRONT_STG+g]),
            .item_in  (div_item[g]),
            .item_out (div_item[g+1])
        );
    end

    hrr_back u_back (
        .clk              (clk),
        .en               (en[NUM_STG-1]),
        .item             (div_item[DIV_STG]),
        .res_x            (res_x),
        .res_y            (res_y),
        .zero_denominator (zero_denominator),
        .last_result      (last_result)
    );

    assign in_ready  = en[0];
    assign out_valid = v_reg[NUM_STG-1];

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&v_reg))
        else $error("input blocked with an empty stage");
    a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_denominator) |->
            ((res_x == 32'sh7FFF_FFFF || res_x == -32'sh8000_0000) &&
             (res_y == 32'sh7FFF_FFFF || res_y == -32'sh8000_0000)))
        else $error("zero denominator without saturated residuals");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && v_reg[NUM_STG-2]) |=> (out_valid && v_reg[NUM_STG-2]))
        else $error("stalled item lost");
`endif

endmodule

### tb/tb_homography_reprojection_residual_unit.sv
module tb_homography_reprojection_residual_unit;
    import hrr_pkg::*;

    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic        zden;
        logic        last;
    } residual_t;

    class residual_scoreboard;
        logic signed [31:0] hom [NUM_REGS];
        residual_t          pending_q [$];
        int                 errors;

        function new();
            errors = 0;
            foreach (hom[i])
                hom[i] = 0;
            hom[IDX_R0C0] = ONE_Q20;
            hom[IDX_R1C1] = ONE_Q20;
        endfunction

        function logic signed [63:0] row_sum(logic signed [31:0] a, logic signed [31:0] b,
                                             logic signed [31:0] c, logic signed [31:0] x,
                                             logic signed [31:0] y, logic signed [31:0] w);
            logic signed [63:0] pa;
            logic signed [63:0] pb;
            logic signed [63:0] pc;
            pa = a * x;
            pb = b * y;
            pc = c * w;
            return (pa >>> 2) + (pb >>> 2) + (pc >>> 2);
        endfunction

        function logic [31:0] sat32(logic signed [127:0] v);
            if (v > 128'sd2147483647)
                return 32'h7FFF_FFFF;
            if (v < -128'sd2147483648)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        function logic [31:0] residual(logic signed [63:0] num, logic signed [63:0] den,
                                       logic signed [31:0] refc);
            logic signed [127:0] ns;
            logic signed [127:0] ds;
            logic signed [127:0] quo;
            logic signed [127:0] proj;
            ns = num;
            ds = den;
            if (ns < 0)
                ns = -ns;
            if (ds < 0)
                ds = -ds;
            if (ns / ds >= 128'sd16777216)
                quo = 128'sd1 <<< 40;
            else
                quo = (ns <<< 16) / ds;
            proj = ((num < 0) != (den < 0)) ? -quo : quo;
            return sat32(proj - 128'(refc));
        endfunction

        function void note_transfer(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] w, logic signed [31:0] rx,
                                    logic signed [31:0] ry, logic lp);
            logic signed [63:0] q0;
            logic signed [63:0] q1;
            logic signed [63:0] q2;
            residual_t          e;
            q0 = row_sum(hom[0], hom[1], hom[2], x, y, w);
            q1 = row_sum(hom[3], hom[4], hom[5], x, y, w);
            q2 = row_sum(hom[6], hom[7], signed'(ONE_Q20), x, y, w);
            e.last = lp;
            if (q2 == 0)
            begin
                e.zden = 1'b1;
                e.rx   = (q0 >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                e.ry   = (q1 >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            else
            begin
                e.zden = 1'b0;
                e.rx   = residual(q0, q2, rx);
                e.ry   = residual(q1, q2, ry);
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [31:0] rx, logic [31:0] ry, logic zd, logic lr);
            residual_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: res_x %h res_y %h",
                         $time, rx, ry);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (rx !== e.rx)
            begin
                $display("%0t: res_x expected %h actual %h", $time, e.rx, rx);
                errors++;
            end
            if (ry !== e.ry)
            begin
                $display("%0t: res_y expected %h actual %h", $time, e.ry, ry);
                errors++;
            end
            if (zd !== e.zden)
            begin
                $display("%0t: zero_denominator expected %b actual %b", $time, e.zden, zd);
                errors++;
            end
            if (lr !== e.last)
            begin
                $display("%0t: last_result expected %b actual %b", $time, e.last, lr);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [31:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_w;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic              last_point;
    logic              out_valid;
    logic              out_ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic              zero_denominator;
    logic              last_result;

    residual_scoreboard sb;
    bit                 no_gaps;
    bit                 long_hold;
    int                 cycle_count;

    homography_reprojection_residual_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
        sb = new();

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_transfer(src_x, src_y, src_w, ref_x, ref_y, last_point);
        if (rst_n && out_valid && out_ready)
            sb.check_result(res_x, res_y, zero_denominator, last_result);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000)
        begin
            $display("homography_reprojection_residual_unit verification failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 10);
            if (long_hold)
            begin
                long_hold = 1'b0;
                n = 200;
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] w,
                              logic [31:0] rx, logic [31:0] ry, logic lp);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_x      <= x;
        src_y      <= y;
        src_w      <= w;
        ref_x      <= rx;
        ref_y      <= ry;
        last_point <= lp;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic write_hom(int idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx[IDX_W-1:0];
        cfg_data  <= val;
        sb.hom[idx] = val;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic load_matrix(int kind);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (kind)
                0: write_hom(i, (i == 0 || i == 4) ? ONE_Q20 : 32'h0);
                1: write_hom(i, 32'h7FFF_FFFF);
                2: write_hom(i, 32'h8000_0000);
                3: write_hom(i, $urandom());
                4: write_hom(i, (i < 6) ? 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))
                                        : 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11)));
                default: write_hom(i, (i >= 6) ? 32'h0
                                               : 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)));
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:    return 32'($signed($urandom_range(0, 3)) - 1);
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0:    return 32'h0;
            1:    return $urandom();
            default: return 32'($urandom_range(1 << 14, 1 << 18));
        endcase
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point(pick_coord(), pick_coord(), pick_weight(), pick_coord(), pick_coord(),
                       1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        src_x      = '0;
        src_y      = '0;
        src_w      = '0;
        ref_x      = '0;
        ref_y      = '0;
        last_point = 1'b0;
        no_gaps    = 1'b0;
        long_hold  = 1'b0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, identity homography from reset
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 1'b1);
        send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0100, 32'h7FFF_FFFF,
                   32'h8000_0000, 1'b0);
        drain();
        load_matrix(1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h8765_4321, 1'b1);
        drain();
        load_matrix(2);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
        drain();

        load_matrix(4);
        random_points(150);
        drain();
        load_matrix(5);
        no_gaps = 1'b1;
        random_points(100);
        no_gaps = 1'b0;
        drain();
        load_matrix(4);
        long_hold = 1'b1;
        no_gaps = 1'b1;
        random_points(120);
        no_gaps = 1'b0;
        drain();
        load_matrix(3);
        random_points(100);
        drain();
        load_matrix(1);
        random_points(40);
        drain();
        load_matrix(2);
        random_points(40);
        drain();
        load_matrix(0);
        random_points(150);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("homography_reprojection_residual_unit verification clean");
        else
            $display("homography_reprojection_residual_unit verification failed");
        $finish;
    end

endmodule
